// ===== design/tlbpt_pkg.sv =====
// Shared types, constants and helpers for the TLB and page table translator.
package tlbpt_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_BITS   = 8;
    localparam int OFFSET_BITS = 8;
    localparam int ADDR_W      = 16;

    localparam int NUM_PAGES   = 1 << PAGE_BITS;
    localparam int TLB_IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int FREE_W      = PAGE_BITS + 1;
    localparam int PHYS_W      = PAGE_BITS + OFFSET_BITS;

    typedef logic [PAGE_BITS-1:0]   page_t;
    typedef logic [PAGE_BITS-1:0]   frame_t;
    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [TLB_IDX_W-1:0]   tlb_idx_t;
    typedef logic [FREE_W-1:0]      free_cnt_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // TLB lookup answer
    typedef struct packed {
        logic   hit;
        frame_t frame;
    } tlb_result_t;

    // TLB fill request (slot taken from the round-robin pointer)
    typedef struct packed {
        logic   en;
        page_t  page;
        frame_t frame;
    } tlb_fill_t;

    // Page table read data
    typedef struct packed {
        logic   valid;
        frame_t frame;
    } pm_entry_t;

    // Page table write
    typedef struct packed {
        logic   en;
        page_t  page;
        frame_t frame;
    } pm_write_t;

    // Page number from a logical address; bits above page+offset are dropped
    function automatic page_t addr_page(addr_t addr);
        addr_t shifted;
        shifted = addr >> OFFSET_BITS;
        return page_t'(shifted);
    endfunction

    function automatic offset_t addr_offset(addr_t addr);
        return offset_t'(addr);
    endfunction

    // Frame and offset joined, then fitted to the address width
    function automatic addr_t make_phys(frame_t frame, offset_t offset);
        logic [PHYS_W-1:0] full;
        full = {frame, offset};
        return addr_t'(full);
    endfunction

endpackage

// ===== design/tlb_page_table_translator.sv =====
// Top level: demand-paged address translator, TLB in front of a page table.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, logical_address            | request in
//  out     | out_valid, out_stall, physical_address,        | result out
//          | tlb_hit, page_fault                            |
//
// Each request passes through the registered page table read, then a lookup step to
// decide hit/miss/fault and write back frame, TLB slot and free-frame count.
// The output register lets the next request enter while a result waits; a
// stalled output holds the lookup step until it drains.
// Reset is immediate: TLB and page table valid bits are flops, no sweep.
module tlb_page_table_translator
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [15:0]              logical_address,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [15:0]              physical_address,
    output logic                     tlb_hit,
    output logic                     page_fault
);

    tlbpt_pkg::state_t      state_reg, state_next;
    tlbpt_pkg::page_t       page_reg;
    tlbpt_pkg::offset_t     offset_reg;
    tlbpt_pkg::free_cnt_t   free_frame_reg, free_frame_next;
    logic                   out_valid_reg, out_valid_next;
    tlbpt_pkg::addr_t       phys_reg, phys_next;
    logic                   hit_reg, hit_next;
    logic                   fault_reg, fault_next;

    logic                   accept;
    logic                   load_out;
    tlbpt_pkg::tlb_result_t tlb_res;
    tlbpt_pkg::tlb_fill_t   tlb_fill;
    tlbpt_pkg::pm_entry_t   pm_rd;
    tlbpt_pkg::pm_write_t   pm_wr;
    tlbpt_pkg::frame_t      frame_sel;
    tlbpt_pkg::frame_t      new_frame;

    assign accept    = in_valid && !in_stall;
    assign new_frame = tlbpt_pkg::frame_t'(free_frame_reg);

    tlbpt_tlb u_tlb
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_page (page_reg),
        .result      (tlb_res),
        .fill        (tlb_fill)
    );

    tlbpt_page_map u_page_map
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_page (tlbpt_pkg::addr_page(logical_address)),
        .rd_data (pm_rd),
        .wr      (pm_wr)
    );

    // Sequencer: next state, write-back and output load
    always_comb
    begin
        state_next      = state_reg;
        in_stall        = 1'b1;
        load_out        = 1'b0;
        free_frame_next = free_frame_reg;
        hit_next        = hit_reg;
        fault_next      = fault_reg;
        phys_next       = phys_reg;
        frame_sel       = pm_rd.frame;
        tlb_fill        = '0;
        pm_wr           = '0;

        case (state_reg)
            tlbpt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    state_next = tlbpt_pkg::ST_LOOKUP;
            end
            tlbpt_pkg::ST_LOOKUP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = tlbpt_pkg::ST_IDLE;
                    hit_next   = tlb_res.hit;
                    fault_next = 1'b0;
                    if (tlb_res.hit)
                        frame_sel = tlb_res.frame;
                    else if (pm_rd.valid)
                        frame_sel = pm_rd.frame;
                    else
                    begin
                        // page fault: take next free frame
                        frame_sel      = new_frame;
                        fault_next     = 1'b1;
                        pm_wr.en       = 1'b1;
                        pm_wr.page     = page_reg;
                        pm_wr.frame    = new_frame;
                        tlb_fill.en    = 1'b1;
                        tlb_fill.page  = page_reg;
                        tlb_fill.frame = new_frame;
                        if (free_frame_reg < tlbpt_pkg::free_cnt_t'(tlbpt_pkg::NUM_PAGES))
                            free_frame_next = free_frame_reg + 1'b1;
                    end
                    phys_next = tlbpt_pkg::make_phys(frame_sel, offset_reg);
                end
            end
            default:
            begin
                state_next = tlbpt_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid tracking
    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tlbpt_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            free_frame_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            free_frame_reg <= free_frame_next;
        end
    end

    // Request capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg   <= tlbpt_pkg::addr_page(logical_address);
            offset_reg <= tlbpt_pkg::addr_offset(logical_address);
        end
        phys_reg  <= phys_next;
        hit_reg   <= hit_next;
        fault_reg <= fault_next;
    end

    assign out_valid        = out_valid_reg;
    assign physical_address = phys_reg;
    assign tlb_hit          = hit_reg;
    assign page_fault       = fault_reg;

endmodule

// ===== design/tlbpt_tlb.sv =====
// Fully associative TLB with round-robin fill pointer.
module tlbpt_tlb
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tlbpt_pkg::page_t       lookup_page,
    output tlbpt_pkg::tlb_result_t result,
    input  tlbpt_pkg::tlb_fill_t   fill
);

    logic [tlbpt_pkg::TLB_ENTRIES-1:0] slot_valid_reg;
    tlbpt_pkg::page_t                  slot_page_reg  [tlbpt_pkg::TLB_ENTRIES];
    tlbpt_pkg::frame_t                 slot_frame_reg [tlbpt_pkg::TLB_ENTRIES];
    tlbpt_pkg::tlb_idx_t               fill_ptr_reg;
    tlbpt_pkg::tlb_idx_t               fill_ptr_next;

    // Parallel compare; lowest matching slot wins
    always_comb
    begin
        result.hit   = 1'b0;
        result.frame = '0;
        for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (slot_valid_reg[i] && (slot_page_reg[i] == lookup_page))
            begin
                result.hit   = 1'b1;
                result.frame = slot_frame_reg[i];
            end
        end
    end

    // Pointer advance with wrap
    always_comb
    begin
        if (fill_ptr_reg == tlbpt_pkg::tlb_idx_t'(tlbpt_pkg::TLB_ENTRIES - 1))
            fill_ptr_next = '0;
        else
            fill_ptr_next = fill_ptr_reg + 1'b1;
    end

    // Valid bits and pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            fill_ptr_reg   <= '0;
        end
        else if (fill.en)
        begin
            slot_valid_reg[fill_ptr_reg] <= 1'b1;
            fill_ptr_reg                 <= fill_ptr_next;
        end
    end

    // Slot payload
    always_ff @(posedge clk)
    begin
        if (fill.en)
        begin
            slot_page_reg[fill_ptr_reg]  <= fill.page;
            slot_frame_reg[fill_ptr_reg] <= fill.frame;
        end
    end

endmodule

// ===== design/tlbpt_page_map.sv =====
// Page table: synchronous frame memory with per-page valid flops.
module tlbpt_page_map
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  tlbpt_pkg::page_t     rd_page,
    output tlbpt_pkg::pm_entry_t rd_data,
    input  tlbpt_pkg::pm_write_t wr
);

    tlbpt_pkg::frame_t               map_mem [tlbpt_pkg::NUM_PAGES];
    logic [tlbpt_pkg::NUM_PAGES-1:0] map_valid_reg;
    logic                            rd_valid_reg;
    tlbpt_pkg::frame_t               rd_frame_reg;

    // Frame memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
            map_mem[wr.page] <= wr.frame;
        if (rd_en)
            rd_frame_reg <= map_mem[rd_page];
    end

    // Valid bits clear at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
                map_valid_reg[wr.page] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= map_valid_reg[rd_page];
        end
    end

    assign rd_data.valid = rd_valid_reg;
    assign rd_data.frame = rd_frame_reg;

endmodule

// ===== design/tlbpt_checker.sv =====
// Port-level checks for the translator, bound to the top level.
module tlbpt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] physical_address,
    input logic        tlb_hit,
    input logic        page_fault
);

    // A TLB hit never assigns a frame
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tlb_hit && page_fault))
        else $error("tlb_hit and page_fault both set");

    // One request in flight: stall follows an accept
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while previous still in lookup");

    // A new result appears only after the lookup cycle
    a_result_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a lookup cycle");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(physical_address)
            && $stable(tlb_hit) && $stable(page_fault)))
        else $error("stalled result changed");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault)
);
